// File: rtl/sdepq_pkg.sv
// Shared types and constants of the sorted double-ended priority queue.
package sdepq_pkg;

    localparam int RANK_W  = 16;
    localparam int PAY_W   = 32;
    localparam int MODE_W  = 3;
    localparam int COUNT_W = 5;

    // Operation codes carried in the mode field of a request.
    typedef enum logic [MODE_W-1:0] {
        MODE_INSERT     = 3'd0,
        MODE_POP_FRONT  = 3'd1,
        MODE_POP_BACK   = 3'd2,
        MODE_PEEK_FRONT = 3'd3,
        MODE_PEEK_BACK  = 3'd4,
        MODE_CLEAR      = 3'd5
    } mode_t;

    // What every cell does in a given cycle.
    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_INSERT,
        CELL_SHIFT_UP
    } cell_op_t;

    // Broadcast from the top level to every cell.
    typedef struct packed {
        cell_op_t                  op;
        logic signed [RANK_W-1:0]  rank;
    } cell_ctrl_t;

    typedef struct packed {
        logic [MODE_W-1:0]         mode;
        logic signed [RANK_W-1:0]  in_rank;
        logic [PAY_W-1:0]          in_payload;
    } req_t;

    typedef struct packed {
        logic                      ok;
        logic signed [RANK_W-1:0]  out_rank;
        logic [PAY_W-1:0]          out_payload;
        logic [COUNT_W-1:0]        count;
        logic                      empty_res;
    } res_t;

endpackage

// File: rtl/sorted_double_ended_priority_queue_top.sv
// Top level of the sorted double-ended priority queue built as a row of shift cells.
//
//  Channel   Signals              Direction  Handshake
//  request   start, busy, req     in         taken when start is high and busy is low
//  result    done, res            out        done marks res for one cycle, never stalled
//
// Every request is taken when presented and its result appears, marked by done, in the
// cycle after it was taken, so a new request may be issued in every cycle. The rate is set
// by the row of cells: all of them compare the new rank in parallel and shift together.
// busy is held low. Reset clears the fill count and the result strobe; the cells' contents
// are not cleared, since only slots below the fill count are ever read.
// The receiver of results cannot stall, so no result is ever held back.
module sorted_double_ended_priority_queue_top #(
    parameter int CAPACITY     = 16,
    parameter int PAYLOAD_BITS = 32
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  sdepq_pkg::req_t   req,
    output logic              done,
    output sdepq_pkg::res_t   res
);
    import sdepq_pkg::*;

    localparam int CNT_W  = $clog2(CAPACITY + 1);
    localparam int PEXT_W = (PAYLOAD_BITS > PAY_W) ? PAYLOAD_BITS : PAY_W;
    localparam int CEXT_W = (CNT_W > COUNT_W) ? CNT_W : COUNT_W;

    // Fill count, and the registered result with its strobe.
    logic [CNT_W-1:0] count_reg, count_next;
    logic             done_reg;
    res_t             res_reg, res_next;

    logic accept;
    logic full;
    logic is_empty;

    // Per-cell wiring between neighbors.
    logic signed [RANK_W-1:0] cell_rank    [CAPACITY];
    logic [PAYLOAD_BITS-1:0]  cell_payload [CAPACITY];
    logic                     cell_ge      [CAPACITY];
    logic                     cell_occ     [CAPACITY];
    logic                     cell_tail    [CAPACITY];

    cell_ctrl_t               ctrl;
    logic [PEXT_W-1:0]        in_pay_ext;
    logic [PAYLOAD_BITS-1:0]  new_payload;

    // Front and back entries as seen before this request changes anything.
    logic signed [RANK_W-1:0] tail_rank;
    logic [PAYLOAD_BITS-1:0]  tail_payload;
    logic [PEXT_W-1:0]        front_pay_ext;
    logic [PEXT_W-1:0]        tail_pay_ext;
    logic [CEXT_W-1:0]        count_ext;

    assign busy     = 1'b0;
    assign accept   = start && !busy;
    assign full     = (count_reg == CNT_W'(CAPACITY));
    assign is_empty = (count_reg == '0);

    // The incoming payload is kept to its low PAYLOAD_BITS bits.
    assign in_pay_ext  = PEXT_W'(req.in_payload);
    assign new_payload = in_pay_ext[PAYLOAD_BITS-1:0];

    // A cell is occupied below the fill count; the tail is the last occupied cell.
    always_comb
    begin
        for (int i = 0; i < CAPACITY; i++)
        begin
            cell_occ[i]  = (CNT_W'(i) < count_reg);
            cell_tail[i] = (CNT_W'(i) == (count_reg - CNT_W'(1)));
        end
    end

    // The back entry is picked out with an AND-OR over the row; exactly one cell is the
    // tail whenever the queue holds anything.
    always_comb
    begin
        tail_rank    = '0;
        tail_payload = '0;
        for (int i = 0; i < CAPACITY; i++)
        begin
            tail_rank    = tail_rank    | (cell_rank[i]    & {RANK_W{cell_tail[i]}});
            tail_payload = tail_payload | (cell_payload[i] & {PAYLOAD_BITS{cell_tail[i]}});
        end
    end

    assign front_pay_ext = PEXT_W'(cell_payload[0]);
    assign tail_pay_ext  = PEXT_W'(tail_payload);

    // Request decoder: picks the cell operation, the new fill count and the result fields.
    always_comb
    begin
        ctrl.op              = CELL_HOLD;
        ctrl.rank            = req.in_rank;
        count_next           = count_reg;
        res_next.ok          = 1'b0;
        res_next.out_rank    = '0;
        res_next.out_payload = '0;
        if (accept)
        begin
            unique case (req.mode)
                MODE_INSERT:
                begin
                    if (!full)
                    begin
                        ctrl.op     = CELL_INSERT;
                        count_next  = count_reg + CNT_W'(1);
                        res_next.ok = 1'b1;
                    end
                end
                MODE_POP_FRONT:
                begin
                    if (!is_empty)
                    begin
                        ctrl.op              = CELL_SHIFT_UP;
                        count_next           = count_reg - CNT_W'(1);
                        res_next.ok          = 1'b1;
                        res_next.out_rank    = cell_rank[0];
                        res_next.out_payload = front_pay_ext[PAY_W-1:0];
                    end
                end
                MODE_POP_BACK:
                begin
                    if (!is_empty)
                    begin
                        count_next           = count_reg - CNT_W'(1);
                        res_next.ok          = 1'b1;
                        res_next.out_rank    = tail_rank;
                        res_next.out_payload = tail_pay_ext[PAY_W-1:0];
                    end
                end
                MODE_PEEK_FRONT:
                begin
                    if (!is_empty)
                    begin
                        res_next.ok          = 1'b1;
                        res_next.out_rank    = cell_rank[0];
                        res_next.out_payload = front_pay_ext[PAY_W-1:0];
                    end
                end
                MODE_PEEK_BACK:
                begin
                    if (!is_empty)
                    begin
                        res_next.ok          = 1'b1;
                        res_next.out_rank    = tail_rank;
                        res_next.out_payload = tail_pay_ext[PAY_W-1:0];
                    end
                end
                MODE_CLEAR:
                begin
                    count_next  = '0;
                    res_next.ok = 1'b1;
                end
                default:
                begin
                    // Unused codes change nothing and report failure.
                    count_next = count_reg;
                end
            endcase
        end
        count_ext          = CEXT_W'(count_next);
        res_next.count     = count_ext[COUNT_W-1:0];
        res_next.empty_res = (count_next == '0);
    end

    // The row of cells. Cell 0 is the front; it sees a virtual neighbor that always
    // keeps its entry, so a new highest rank lands there.
    for (genvar g = 0; g < CAPACITY; g++)
    begin : g_cell
        logic                     prev_ge;
        logic signed [RANK_W-1:0] prev_rank;
        logic [PAYLOAD_BITS-1:0]  prev_payload;
        logic signed [RANK_W-1:0] next_rank;
        logic [PAYLOAD_BITS-1:0]  next_payload;

        if (g == 0)
        begin : g_first
            assign prev_ge      = 1'b1;
            assign prev_rank    = '0;
            assign prev_payload = '0;
        end
        else
        begin : g_inner
            assign prev_ge      = cell_ge[g-1];
            assign prev_rank    = cell_rank[g-1];
            assign prev_payload = cell_payload[g-1];
        end

        if (g == CAPACITY - 1)
        begin : g_last
            assign next_rank    = '0;
            assign next_payload = '0;
        end
        else
        begin : g_body
            assign next_rank    = cell_rank[g+1];
            assign next_payload = cell_payload[g+1];
        end

        sdepq_cell #(
            .PAYLOAD_BITS (PAYLOAD_BITS)
        ) u_cell (
            .clk          (clk),
            .ctrl         (ctrl),
            .new_payload  (new_payload),
            .occupied     (cell_occ[g]),
            .prev_ge      (prev_ge),
            .prev_rank    (prev_rank),
            .prev_payload (prev_payload),
            .next_rank    (next_rank),
            .next_payload (next_payload),
            .rank         (cell_rank[g]),
            .payload      (cell_payload[g]),
            .ge           (cell_ge[g])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            done_reg  <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            res_reg <= res_next;
        end
    end

    assign done = done_reg;
    assign res  = res_reg;

    // The fill count never passes the number of cells.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(CAPACITY))
        else $error("fill count exceeds capacity");

    // Every taken request gives exactly one result in the next cycle.
    a_done_follows: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> done_reg)
        else $error("request taken without a result");

    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        !accept |=> !done_reg)
        else $error("result without a request");

    // A successful insert grows the queue by one.
    a_insert_grows: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && req.mode == MODE_INSERT && !full) |=>
            (count_reg == $past(count_reg) + CNT_W'(1)))
        else $error("insert did not grow the queue");

    // The empty flag of a result agrees with the fill count.
    a_empty_flag: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> (res_reg.empty_res == (count_reg == '0)))
        else $error("empty flag disagrees with fill count");

endmodule

// File: rtl/sdepq_cell.sv
// One slot of the sorted shift array: holds one entry and moves it to a neighbor on demand.
module sdepq_cell #(
    parameter int PAYLOAD_BITS = 32
) (
    input  logic                                clk,
    input  sdepq_pkg::cell_ctrl_t               ctrl,
    input  logic [PAYLOAD_BITS-1:0]             new_payload,
    input  logic                                occupied,
    input  logic                                prev_ge,
    input  logic signed [sdepq_pkg::RANK_W-1:0] prev_rank,
    input  logic [PAYLOAD_BITS-1:0]             prev_payload,
    input  logic signed [sdepq_pkg::RANK_W-1:0] next_rank,
    input  logic [PAYLOAD_BITS-1:0]             next_payload,
    output logic signed [sdepq_pkg::RANK_W-1:0] rank,
    output logic [PAYLOAD_BITS-1:0]             payload,
    output logic                                ge
);
    import sdepq_pkg::*;

    logic signed [RANK_W-1:0] rank_reg, rank_next;
    logic [PAYLOAD_BITS-1:0]  payload_reg, payload_next;

    // An occupied cell whose rank is not below the new one keeps its entry on insert,
    // which keeps equal ranks in arrival order.
    assign ge      = occupied && (rank_reg >= ctrl.rank);
    assign rank    = rank_reg;
    assign payload = payload_reg;

    always_comb
    begin
        rank_next    = rank_reg;
        payload_next = payload_reg;
        unique case (ctrl.op)
            CELL_INSERT:
            begin
                if (!ge)
                begin
                    if (prev_ge)
                    begin
                        rank_next    = ctrl.rank;
                        payload_next = new_payload;
                    end
                    else
                    begin
                        rank_next    = prev_rank;
                        payload_next = prev_payload;
                    end
                end
            end
            CELL_SHIFT_UP:
            begin
                rank_next    = next_rank;
                payload_next = next_payload;
            end
            default:
            begin
                rank_next    = rank_reg;
                payload_next = payload_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        rank_reg    <= rank_next;
        payload_reg <= payload_next;
    end

endmodule

// File: tb/tb.sv
// Self-checking testbench of the sorted double-ended priority queue.
`timescale 1ns / 100ps

module tb;
    import sdepq_pkg::*;

    // The block is built with its default size; the predictor mirrors it.
    localparam int CAPACITY = 16;

    // Codes 6 and 7 of the mode field are not operations. The block must ignore them.
    localparam logic [MODE_W-1:0] MODE_SPARE_LO = 3'd6;
    localparam logic [MODE_W-1:0] MODE_SPARE_HI = 3'd7;

    // Rank patterns used by the random phases.
    localparam int RANKS_WIDE    = 0;
    localparam int RANKS_CLOSE   = 1;
    localparam int RANKS_EXTREME = 2;

    // No idling from the sender between these request numbers.
    localparam int STEADY_FIRST = 700;
    localparam int STEADY_LAST  = 1000;

    // One row of the directed part. When spelled_out is set, the result is written in the row;
    // otherwise the predictor supplies it.
    typedef struct {
        req_t rq;
        bit   spelled_out;
        res_t want;
    } plan_row_t;

    logic clk = 1'b0;
    logic rst_n;
    logic start;
    logic busy;
    req_t req;
    logic done;
    res_t res;

    // Mirror of the queue contents, front at slot 0.
    logic signed [RANK_W-1:0] mirror_rank [CAPACITY];
    logic [PAY_W-1:0]         mirror_payload [CAPACITY];
    int                       mirror_fill;

    res_t      pending_results [$];
    plan_row_t plan [$];
    int        error_count;
    int        requests_sent;

    sorted_double_ended_priority_queue_top dut (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .req   (req),
        .done  (done),
        .res   (res)
    );

    // Free-running clock of 10 ns.
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Applies one request to the mirror and returns the result the block must report for it.
    // Equal ranks keep arrival order: a new entry goes behind every entry of rank greater than
    // or equal to its own.
    function automatic res_t apply_to_mirror(req_t rq);
        res_t outcome;
        int   slot;
        outcome = '0;
        case (rq.mode)
            MODE_INSERT:
                if (mirror_fill < CAPACITY)
                begin
                    slot = 0;
                    while (slot < mirror_fill && mirror_rank[slot] >= rq.in_rank)
                        slot++;
                    for (int i = mirror_fill; i > slot; i--)
                    begin
                        mirror_rank[i]    = mirror_rank[i-1];
                        mirror_payload[i] = mirror_payload[i-1];
                    end
                    mirror_rank[slot]    = rq.in_rank;
                    mirror_payload[slot] = rq.in_payload;
                    mirror_fill++;
                    outcome.ok = 1'b1;
                end
            MODE_POP_FRONT:
                if (mirror_fill > 0)
                begin
                    outcome.ok          = 1'b1;
                    outcome.out_rank    = mirror_rank[0];
                    outcome.out_payload = mirror_payload[0];
                    for (int i = 1; i < mirror_fill; i++)
                    begin
                        mirror_rank[i-1]    = mirror_rank[i];
                        mirror_payload[i-1] = mirror_payload[i];
                    end
                    mirror_fill--;
                end
            MODE_POP_BACK:
                if (mirror_fill > 0)
                begin
                    outcome.ok          = 1'b1;
                    outcome.out_rank    = mirror_rank[mirror_fill-1];
                    outcome.out_payload = mirror_payload[mirror_fill-1];
                    mirror_fill--;
                end
            MODE_PEEK_FRONT:
                if (mirror_fill > 0)
                begin
                    outcome.ok          = 1'b1;
                    outcome.out_rank    = mirror_rank[0];
                    outcome.out_payload = mirror_payload[0];
                end
            MODE_PEEK_BACK:
                if (mirror_fill > 0)
                begin
                    outcome.ok          = 1'b1;
                    outcome.out_rank    = mirror_rank[mirror_fill-1];
                    outcome.out_payload = mirror_payload[mirror_fill-1];
                end
            MODE_CLEAR:
            begin
                mirror_fill = 0;
                outcome.ok  = 1'b1;
            end
            default:
                ;
        endcase
        outcome.count     = COUNT_W'(mirror_fill);
        outcome.empty_res = (mirror_fill == 0);
        return outcome;
    endfunction

    // Builds a directed row. The empty flag of a written-out result follows from its count.
    function automatic plan_row_t plan_row(logic [MODE_W-1:0] m, logic signed [RANK_W-1:0] r,
                                           logic [PAY_W-1:0] p, bit spelled_out,
                                           logic ok, logic signed [RANK_W-1:0] orank,
                                           logic [PAY_W-1:0] opay, logic [COUNT_W-1:0] cnt);
        plan_row_t row;
        row.rq.mode          = m;
        row.rq.in_rank       = r;
        row.rq.in_payload    = p;
        row.spelled_out      = spelled_out;
        row.want.ok          = ok;
        row.want.out_rank    = orank;
        row.want.out_payload = opay;
        row.want.count       = cnt;
        row.want.empty_res   = (cnt == 0);
        return row;
    endfunction

    // Chooses an operation. Spare codes and clears are kept rare so that the queue can fill.
    function automatic logic [MODE_W-1:0] pick_mode(int insert_pct);
        int roll;
        if ($urandom_range(99) < insert_pct)
            return MODE_INSERT;
        roll = $urandom_range(99);
        if (roll < 3)
            return MODE_CLEAR;
        if (roll < 6)
            return ($urandom_range(1) != 0) ? MODE_SPARE_HI : MODE_SPARE_LO;
        case ($urandom_range(3))
            0:       return MODE_POP_FRONT;
            1:       return MODE_POP_BACK;
            2:       return MODE_PEEK_FRONT;
            default: return MODE_PEEK_BACK;
        endcase
    endfunction

    // Close ranks produce many ties, which exercise the arrival order of equal ranks.
    function automatic logic signed [RANK_W-1:0] pick_rank(int pattern);
        case (pattern)
            RANKS_CLOSE:
                return RANK_W'($signed($urandom_range(4)) - 2);
            RANKS_EXTREME:
                case ($urandom_range(5))
                    0:       return 16'sh7FFF;
                    1:       return 16'sh8000;
                    2:       return 16'sh0000;
                    3:       return -16'sd1;
                    4:       return 16'sd1;
                    default: return RANK_W'($urandom);
                endcase
            default:
                return RANK_W'($urandom);
        endcase
    endfunction

    // Presents one request, at times after a random gap, and waits for the edge that takes
    // it. The expectation is recorded at that edge; spelled_out rows bring their own.
    task automatic send_request(req_t rq, bit spelled_out, res_t want);
        res_t predicted;
        bit   quiet;
        quiet = (requests_sent >= STEADY_FIRST && requests_sent < STEADY_LAST);
        if (!quiet && $urandom_range(99) < 13)
        begin
            start <= 1'b0;
            @(posedge clk);
            while ($urandom_range(99) < 13)
                @(posedge clk);
        end
        start <= 1'b1;
        req   <= rq;
        do
            @(posedge clk);
        while (busy);
        predicted = apply_to_mirror(rq);
        pending_results.push_back(spelled_out ? want : predicted);
        requests_sent++;
    endtask

    // Every result strobe is matched against the oldest outstanding expectation. Sampling at
    // the edge reads the values of the cycle that the edge closes.
    always @(posedge clk)
    begin
        res_t want;
        if (rst_n && done)
        begin
            if (pending_results.size() == 0)
            begin
                $error("result with nothing outstanding: ok=%0b rank=%0d payload=%h count=%0d",
                       res.ok, res.out_rank, res.out_payload, res.count);
                error_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (res.ok !== want.ok)
                begin
                    $error("ok: expected %0b, got %0b", want.ok, res.ok);
                    error_count++;
                end
                if (res.out_rank !== want.out_rank)
                begin
                    $error("out_rank: expected %0d, got %0d", want.out_rank, res.out_rank);
                    error_count++;
                end
                if (res.out_payload !== want.out_payload)
                begin
                    $error("out_payload: expected %h, got %h", want.out_payload, res.out_payload);
                    error_count++;
                end
                if (res.count !== want.count)
                begin
                    $error("count: expected %0d, got %0d", want.count, res.count);
                    error_count++;
                end
                if (res.empty_res !== want.empty_res)
                begin
                    $error("empty_res: expected %0b, got %0b", want.empty_res, res.empty_res);
                    error_count++;
                end
            end
        end
    end

    // Main sequence: reset, the directed table, random phases, then drain and verdict.
    initial
    begin
        req_t rq;
        int   phase_len [5];
        int   phase_insert [5];
        int   phase_ranks [5];

        rst_n         = 1'b0;
        start         = 1'b0;
        req           = '0;
        error_count   = 0;
        requests_sent = 0;
        mirror_fill   = 0;

        // Directed part. An empty queue rejects every remove and peek, a clear still succeeds,
        // and the spare codes change nothing. The extremes of rank and payload then go in,
        // two equal ranks follow to check their order, and both ends are read and removed.
        plan.push_back(plan_row(MODE_PEEK_FRONT, 16'sd0, 32'h0, 1, 1'b0, 16'sd0, 32'h0, 5'd0));
        plan.push_back(plan_row(MODE_PEEK_BACK,  16'sd0, 32'h0, 1, 1'b0, 16'sd0, 32'h0, 5'd0));
        plan.push_back(plan_row(MODE_POP_FRONT,  16'sd0, 32'h0, 1, 1'b0, 16'sd0, 32'h0, 5'd0));
        plan.push_back(plan_row(MODE_POP_BACK,   16'sd0, 32'h0, 1, 1'b0, 16'sd0, 32'h0, 5'd0));
        plan.push_back(plan_row(MODE_CLEAR,      16'sd0, 32'h0, 1, 1'b1, 16'sd0, 32'h0, 5'd0));
        plan.push_back(plan_row(MODE_SPARE_LO, 16'sh7FFF, 32'hFFFFFFFF, 1,
                                1'b0, 16'sd0, 32'h0, 5'd0));
        plan.push_back(plan_row(MODE_SPARE_HI, 16'sh8000, 32'hFFFFFFFF, 1,
                                1'b0, 16'sd0, 32'h0, 5'd0));
        plan.push_back(plan_row(MODE_INSERT, 16'sh7FFF, 32'hFFFFFFFF, 1,
                                1'b1, 16'sd0, 32'h0, 5'd1));
        plan.push_back(plan_row(MODE_INSERT, 16'sh8000, 32'h0, 1, 1'b1, 16'sd0, 32'h0, 5'd2));
        plan.push_back(plan_row(MODE_INSERT, 16'sd0, 32'h55555555, 0, 1'b0, 16'sd0, 32'h0, 5'd0));
        plan.push_back(plan_row(MODE_INSERT, 16'sd0, 32'hAAAAAAAA, 0, 1'b0, 16'sd0, 32'h0, 5'd0));
        plan.push_back(plan_row(MODE_SPARE_HI, 16'sd0, 32'h0, 0, 1'b0, 16'sd0, 32'h0, 5'd0));
        plan.push_back(plan_row(MODE_PEEK_FRONT, 16'sd0, 32'h0, 1,
                                1'b1, 16'sh7FFF, 32'hFFFFFFFF, 5'd4));
        plan.push_back(plan_row(MODE_PEEK_BACK, 16'sd0, 32'h0, 1,
                                1'b1, 16'sh8000, 32'h0, 5'd4));
        plan.push_back(plan_row(MODE_POP_BACK, 16'sd0, 32'h0, 1, 1'b1, 16'sh8000, 32'h0, 5'd3));
        plan.push_back(plan_row(MODE_POP_FRONT, 16'sd0, 32'h0, 1,
                                1'b1, 16'sh7FFF, 32'hFFFFFFFF, 5'd2));
        plan.push_back(plan_row(MODE_PEEK_BACK, 16'sd0, 32'h0, 0, 1'b0, 16'sd0, 32'h0, 5'd0));
        plan.push_back(plan_row(MODE_POP_FRONT, 16'sd0, 32'h0, 0, 1'b0, 16'sd0, 32'h0, 5'd0));
        plan.push_back(plan_row(MODE_INSERT, -16'sd1, 32'h12345678, 0,
                                1'b0, 16'sd0, 32'h0, 5'd0));
        plan.push_back(plan_row(MODE_CLEAR, 16'sd0, 32'h0, 1, 1'b1, 16'sd0, 32'h0, 5'd0));

        // Random phases: mixed, filling, draining, filling with close ranks, and mixed again.
        // The filling phases reach a full queue and bounce off it; the draining one rests on
        // the empty queue.
        phase_len    = '{400, 350, 300, 300, 300};
        phase_insert = '{50, 80, 25, 70, 55};
        phase_ranks  = '{RANKS_WIDE, RANKS_EXTREME, RANKS_WIDE, RANKS_CLOSE, RANKS_EXTREME};

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (plan[i])
            send_request(plan[i].rq, plan[i].spelled_out, plan[i].want);

        for (int ph = 0; ph < 5; ph++)
        begin
            for (int n = 0; n < phase_len[ph]; n++)
            begin
                rq.mode       = pick_mode(phase_insert[ph]);
                rq.in_rank    = pick_rank(phase_ranks[ph]);
                rq.in_payload = $urandom;
                send_request(rq, 0, '0);
            end
        end

        // Drain: every result arrives in the cycle after its request is taken, so the slack waited
        // out after the last one also catches any stray strobe.
        start <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (5) @(posedge clk);

        if (error_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Watchdog: ends a run that hangs and reports it as a mismatch.
    initial
    begin
        #500000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

// File: filelist.f
rtl/sdepq_pkg.sv
rtl/sdepq_cell.sv
rtl/sorted_double_ended_priority_queue_top.sv
tb/tb.sv
